[sv/greedy_box_suppression_top_defines.svh]
// Assertion macros for the greedy box suppression block
`ifndef GREEDY_BOX_SUPPRESSION_TOP_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_TOP_DEFINES_SVH

// same-cycle implication
`define GBS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gbs assertion failed");

// next-cycle implication
`define GBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gbs assertion failed");

`endif

[sv/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression block
package gbs_pkg;

   localparam int MAX_BOXES = 64;
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);
   localparam int COORD_W   = 16;
   localparam int SCORE_W   = 16;
   localparam int THR_W     = 17;
   localparam logic [THR_W-1:0] THR_RESET = 17'd26214;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [SCORE_W-1:0] score;
   } box_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_FROM_PREV,
      OP_NEW,
      OP_FROM_NEXT,
      OP_TAIL
   } cell_op_type;

endpackage

[sv/gbs_cell.sv]
// One storage cell of the sorted box chain
module gbs_cell (
   input  logic                clock,
   input  gbs_pkg::cell_op_type op,
   input  gbs_pkg::box_type    prev_box,
   input  gbs_pkg::box_type    next_box,
   input  gbs_pkg::box_type    new_box,
   input  gbs_pkg::box_type    tail_box,
   output gbs_pkg::box_type    box
);
   import gbs_pkg::*;

   box_type box_ff;
   box_type box_in;

   always_comb begin
      unique case (op)
         OP_FROM_PREV: box_in = prev_box;
         OP_NEW:       box_in = new_box;
         OP_FROM_NEXT: box_in = next_box;
         OP_TAIL:      box_in = tail_box;
         default:      box_in = box_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign box = box_ff;

endmodule

[sv/gbs_iou.sv]
// Pipelined overlap test of a candidate box against the pivot box
module gbs_iou (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [gbs_pkg::THR_W-1:0] thr,
   input  gbs_pkg::box_type          pivot,
   input  logic                      in_valid,
   input  gbs_pkg::box_type          in_box,
   output logic                      out_valid,
   output logic                      out_keep,
   output gbs_pkg::box_type          out_box,
   output logic                      pipe_busy
);
   import gbs_pkg::*;

   // stage 1: extents
   logic [COORD_W-1:0] min_r, max_l, min_b, max_t;
   logic signed [17:0] iw_in, ih_in, wa_in, ha_in, wb_in, hb_in;
   logic signed [17:0] iw_ff, ih_ff, wa_ff, ha_ff, wb_ff, hb_ff;
   logic               v1_ff;
   box_type            b1_ff;

   always_comb begin
      min_r = (pivot.right < in_box.right) ? pivot.right : in_box.right;
      max_l = (pivot.left > in_box.left) ? pivot.left : in_box.left;
      min_b = (pivot.bottom < in_box.bottom) ? pivot.bottom : in_box.bottom;
      max_t = (pivot.top > in_box.top) ? pivot.top : in_box.top;
      iw_in = $signed({2'b00, min_r}) - $signed({2'b00, max_l}) + 18'sd16;
      ih_in = $signed({2'b00, min_b}) - $signed({2'b00, max_t}) + 18'sd16;
      wa_in = $signed({2'b00, pivot.right}) - $signed({2'b00, pivot.left}) + 18'sd16;
      ha_in = $signed({2'b00, pivot.bottom}) - $signed({2'b00, pivot.top}) + 18'sd16;
      wb_in = $signed({2'b00, in_box.right}) - $signed({2'b00, in_box.left}) + 18'sd16;
      hb_in = $signed({2'b00, in_box.bottom}) - $signed({2'b00, in_box.top}) + 18'sd16;
   end

   // stage 2: areas
   logic signed [35:0] inner_ff, a0_ff, a1_ff;
   logic               nov_ff, v2_ff;
   box_type            b2_ff;

   // stage 3: union
   logic signed [36:0] uni_in;
   logic [32:0]        inner3_ff;
   logic [34:0]        uni3_ff;
   logic               upos3_ff, nov3_ff, v3_ff;
   box_type            b3_ff;

   assign uni_in = 37'(a0_ff) + 37'(a1_ff) - 37'(inner_ff);

   // stage 4: threshold product in two halves
   logic [34:0] plo_ff;
   logic [33:0] phi_ff;
   logic [32:0] inner4_ff;
   logic        upos4_ff, nov4_ff, v4_ff;
   box_type     b4_ff;

   // stage 5: compare
   logic [52:0] lhs, rhs;
   logic        keep_in;
   logic        out_valid_ff, out_keep_ff;
   box_type     out_box_ff;

   always_comb begin
      lhs     = {4'b0, inner4_ff, 16'b0};
      rhs     = {1'b0, phi_ff, 18'b0} + 53'(plo_ff);
      keep_in = nov4_ff || (upos4_ff && !(lhs > rhs));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
      iw_ff <= iw_in;
      ih_ff <= ih_in;
      wa_ff <= wa_in;
      ha_ff <= ha_in;
      wb_ff <= wb_in;
      hb_ff <= hb_in;
      b1_ff <= in_box;

      inner_ff <= iw_ff * ih_ff;
      a0_ff    <= wa_ff * ha_ff;
      a1_ff    <= wb_ff * hb_ff;
      nov_ff   <= (iw_ff <= 18'sd0) || (ih_ff <= 18'sd0);
      b2_ff    <= b1_ff;

      inner3_ff <= inner_ff[32:0];
      uni3_ff   <= uni_in[34:0];
      upos3_ff  <= uni_in > 37'sd0;
      nov3_ff   <= nov_ff;
      b3_ff     <= b2_ff;

      plo_ff    <= 35'(thr * uni3_ff[17:0]);
      phi_ff    <= 34'(thr * uni3_ff[34:18]);
      inner4_ff <= inner3_ff;
      upos4_ff  <= upos3_ff;
      nov4_ff   <= nov3_ff;
      b4_ff     <= b3_ff;

      out_keep_ff <= keep_in;
      out_box_ff  <= b4_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_keep  = out_keep_ff;
   assign out_box   = out_box_ff;
   assign pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff | out_valid_ff;

endmodule

[sv/greedy_box_suppression_top.sv]
// Greedy box suppression: sorted cell chain with a pipelined overlap unit
// Collect: one box per cycle, inserted in score order into the chain while it has room.
// Suppress: per kept box, a pick step, then each remaining box goes through the overlap
// pipeline, which drains before the next pick. Each pick emits the previous pick's box
// in the cycle after it; the last in the cycle after the final pick, with busy low from
// then on. Synchronous reset empties the set.
module greedy_box_suppression_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [gbs_pkg::COORD_W-1:0]      req_left_x,
   input  logic [gbs_pkg::COORD_W-1:0]      req_top_y,
   input  logic [gbs_pkg::COORD_W-1:0]      req_right_x,
   input  logic [gbs_pkg::COORD_W-1:0]      req_bottom_y,
   input  logic [gbs_pkg::SCORE_W-1:0]      req_confidence,
   input  logic                             req_final_box,
   input  logic                             csr_write_enable,
   input  logic [gbs_pkg::THR_W-1:0]        csr_write_data,
   output logic                             rsp_valid,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_left,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_top,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_right,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_bottom,
   output logic [gbs_pkg::SCORE_W-1:0]      rsp_kept_confidence,
   output logic                             rsp_final_kept,
   output logic                             rsp_set_overflowed
);
   import gbs_pkg::*;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_PICK,
      ST_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               ovf_ff, ovf_in;
   logic [THR_W-1:0]   thr_ff;
   box_type            pivot_ff, pivot_in;
   box_type            pend_ff, pend_in;
   logic               pend_v_ff, pend_v_in;
   logic               rv_ff, rv_in;
   logic               rfin_ff, rfin_in;
   box_type            rbox_ff, rbox_in;

   box_type            cells [MAX_BOXES];
   cell_op_type        ops   [MAX_BOXES];
   logic [MAX_BOXES-1:0] take;
   logic [MAX_BOXES-1:0] take_prev;
   box_type            new_box;

   logic               accept, insert, pop, push;
   logic               iou_v, iou_keep, iou_busy;
   box_type            iou_box;

   assign new_box = '{left: req_left_x, top: req_top_y, right: req_right_x,
                      bottom: req_bottom_y, score: req_confidence};
   assign accept  = start && (state_ff == ST_COLLECT);
   assign insert  = accept && (cnt_ff != CNT_W'(MAX_BOXES));
   assign pop     = ((state_ff == ST_PICK) && (cnt_ff != '0)) ||
                    ((state_ff == ST_SCAN) && (left_ff != '0));
   assign push    = (state_ff == ST_SCAN) && iou_v && iou_keep;

   always_comb begin
      for (int i = 0; i < MAX_BOXES; i++) begin
         take[i] = (CNT_W'(i) >= cnt_ff) || (cells[i].score < req_confidence);
      end
      take_prev = {take[MAX_BOXES-2:0], 1'b0};
      for (int i = 0; i < MAX_BOXES; i++) begin
         ops[i] = OP_HOLD;
         if (insert) begin
            if (take[i]) begin
               ops[i] = take_prev[i] ? OP_FROM_PREV : OP_NEW;
            end
         end else if (pop) begin
            ops[i] = (push && (CNT_W'(i) == cnt_ff - CNT_W'(1))) ? OP_TAIL : OP_FROM_NEXT;
         end else if (push && (CNT_W'(i) == cnt_ff)) begin
            ops[i] = OP_TAIL;
         end
      end
   end

   for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
      gbs_cell u_cell (
         .clock    (clock),
         .op       (ops[g]),
         .prev_box ((g == 0) ? new_box : cells[(g == 0) ? 0 : g-1]),
         .next_box ((g == MAX_BOXES-1) ? cells[g] : cells[(g == MAX_BOXES-1) ? g : g+1]),
         .new_box  (new_box),
         .tail_box (iou_box),
         .box      (cells[g])
      );
   end

   gbs_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .pivot     (pivot_ff),
      .in_valid  ((state_ff == ST_SCAN) && pop),
      .in_box    (cells[0]),
      .out_valid (iou_v),
      .out_keep  (iou_keep),
      .out_box   (iou_box),
      .pipe_busy (iou_busy)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff - CNT_W'(pop) + CNT_W'(push) + CNT_W'(insert);
      left_in   = left_ff;
      ovf_in    = ovf_ff;
      pivot_in  = pivot_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      rv_in     = 1'b0;
      rfin_in   = 1'b0;
      rbox_in   = rbox_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (!insert) begin
                  ovf_in = 1'b1;
               end
               if (req_final_box) begin
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            rv_in   = pend_v_ff;
            rfin_in = (cnt_ff == '0);
            rbox_in = pend_ff;
            if (cnt_ff == '0) begin
               pend_v_in = 1'b0;
               state_in  = ST_COLLECT;
            end else begin
               pivot_in  = cells[0];
               pend_in   = cells[0];
               pend_v_in = 1'b1;
               left_in   = cnt_ff - CNT_W'(1);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pop) begin
               left_in = left_ff - CNT_W'(1);
            end else if (!iou_busy) begin
               state_in = ST_PICK;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_COLLECT;
         cnt_ff    <= '0;
         left_ff   <= '0;
         ovf_ff    <= 1'b0;
         thr_ff    <= THR_RESET;
         pend_v_ff <= 1'b0;
         rv_ff     <= 1'b0;
         rfin_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
         ovf_ff    <= (rv_in && rfin_in) ? 1'b0 : ovf_in;
         pend_v_ff <= pend_v_in;
         rv_ff     <= rv_in;
         rfin_ff   <= rfin_in;
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
      end
      pivot_ff <= pivot_in;
      pend_ff  <= pend_in;
      rbox_ff  <= rbox_in;
   end

   logic ovf_out_ff;
   always_ff @(posedge clock) begin
      ovf_out_ff <= ovf_ff;
   end

   assign busy                = (state_ff != ST_COLLECT);
   assign rsp_valid           = rv_ff;
   assign rsp_final_kept      = rfin_ff;
   assign rsp_kept_left       = rbox_ff.left;
   assign rsp_kept_top        = rbox_ff.top;
   assign rsp_kept_right      = rbox_ff.right;
   assign rsp_kept_bottom     = rbox_ff.bottom;
   assign rsp_kept_confidence = rbox_ff.score;
   assign rsp_set_overflowed  = ovf_out_ff;

endmodule

[sv/gbs_checker.sv]
// Port-level checks for the greedy box suppression block, with bind
`include "greedy_box_suppression_top_defines.svh"
module gbs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_final_box,
   input logic rsp_valid,
   input logic rsp_final_kept
);
   `GBS_ASSERT_NEXT(a_close_busy, clock, reset, start && !busy && req_final_box, busy)
   `GBS_ASSERT_NEXT(a_final_gap, clock, reset, rsp_valid && rsp_final_kept, !rsp_valid)
   `GBS_ASSERT_NOW(a_idle_final, clock, reset, rsp_valid && !busy, rsp_final_kept)
   `GBS_ASSERT_NOW(a_busy_rise, clock, reset, $rose(busy), $past(start))

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_final_box  (req_final_box),
   .rsp_valid      (rsp_valid),
   .rsp_final_kept (rsp_final_kept)
);
